FILE: src/gcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_pkg: shared types and constants of the command blitter
// bus item codes, register offsets, opcodes, status codes and sequencer states
// ----------------------------------------------------------------------------
package gcb_pkg;

  typedef enum logic [2:0] {
    ITEM_REG_RD = 3'd0,
    ITEM_REG_WR = 3'd1,
    ITEM_MEM_RD = 3'd2,
    ITEM_MEM_WR = 3'd3,
    ITEM_VBLANK = 3'd4
  } item_e;

  typedef enum logic [2:0] {
    ST_READY   = 3'd0,
    ST_BUSY    = 3'd1,
    ST_BADADDR = 3'd2,
    ST_BADOP   = 3'd3,
    ST_NOBLOCK = 3'd4
  } status_e;

  localparam logic [6:0] OP_INFO   = 7'd0;
  localparam logic [6:0] OP_FILL   = 7'd1;
  localparam logic [6:0] OP_COPY   = 7'd2;
  localparam logic [6:0] OP_SCROLL = 7'd3;
  localparam logic [6:0] OP_WAIT   = 7'd4;

  localparam logic [15:0] REG_CMD    = 16'h03E8;
  localparam logic [15:0] REG_PTRL   = 16'h03E9;
  localparam logic [15:0] REG_PTRH   = 16'h03EA;
  localparam logic [15:0] GUARD_LOW  = 16'h0400;
  localparam logic [15:0] PTR_HIGH   = 16'hFFF0;
  localparam int unsigned BLOCK_BIT  = 7;

  localparam logic [1:0] CFG_VERSION  = 2'd0;
  localparam logic [1:0] CFG_SPRITES  = 2'd1;
  localparam logic [1:0] CFG_OP_MASK  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEMRD,
    S_ARG,
    S_DISPATCH,
    S_INFO,
    S_FILL,
    S_CPRD,
    S_CPWAIT,
    S_CPST,
    S_CPOUT,
    S_CPOUTW,
    S_CPWR,
    S_DONE
  } state_e;

endpackage

FILE: src/gpu_command_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_command_blitter: register-windowed blitter with its own byte memory
// bus items drive registers and memory; commands walk memory via a sequencer
// ----------------------------------------------------------------------------
// a command first fetches its 16 argument bytes, then fills or copies byte
// by byte; the pace of both is set by the single port of the main memory.
// throughput: one request at a time; the input stalls until the result is taken.
// reset: status ready, pointer 0, no vblank wait, info registers at defaults;
// memories are not cleared.
module gpu_command_blitter import gcb_pkg::*; #(
  parameter int unsigned MEM_DEPTH         = 65536,
  parameter int unsigned COPY_BUFFER_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [2:0]  status_code_o,
  output logic        scroll_valid_o,
  output logic [7:0]  scroll_x_o,
  output logic [7:0]  scroll_y_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned MAW = $clog2(MEM_DEPTH);
  localparam int unsigned CAW = $clog2(COPY_BUFFER_DEPTH);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] cbuf [COPY_BUFFER_DEPTH];

  state_e state_q, state_d;
  logic [7:0] ver_q, spr_q, opm_q;
  status_e status_q, status_d;
  logic [15:0] ptr_q, ptr_d;
  logic wait_q, wait_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0] arg_q [16];
  logic [4:0] idx_q, idx_d;
  logic [7:0] row_q, row_d, col_q, col_d;
  logic [15:0] rbase_q, rbase_d;
  logic [16:0] k_q, k_d;
  logic [7:0] cmdb_q, cmdb_d;

  logic ov_q, ov_d;
  logic [7:0] rd_q, rd_d, sx_q, sx_d, sy_q, sy_d;
  logic sv_q, sv_d;

  // memory port
  logic mem_we, mem_re;
  logic [15:0] mem_a;
  logic [7:0] mem_wd, mem_rd_q;
  logic cb_we, cb_re;
  logic [16:0] cb_a;
  logic [7:0] cb_wd, cb_rd_q;
  logic arg_we;
  logic [3:0] arg_wi;

  always_ff @(posedge clk_i) begin
    if (mem_we && {16'd0, mem_a} < 32'(MEM_DEPTH)) mem[mem_a[MAW-1:0]] <= mem_wd;
    if (mem_re) mem_rd_q <= mem[mem_a[MAW-1:0]];
    if (cb_we && {15'd0, cb_a} < 32'(COPY_BUFFER_DEPTH)) cbuf[cb_a[CAW-1:0]] <= cb_wd;
    if (cb_re) cb_rd_q <= cbuf[cb_a[CAW-1:0]];
  end

  logic mem_in_q, cb_in_q;
  logic [15:0] a_rd_d;
  assign a_rd_d = mem_a;
  always_ff @(posedge clk_i) begin
    if (mem_re) mem_in_q <= {16'd0, a_rd_d} < 32'(MEM_DEPTH);
    if (cb_re) cb_in_q <= {15'd0, cb_a} < 32'(COPY_BUFFER_DEPTH);
    if (arg_we) arg_q[arg_wi] <= mem_in_q ? mem_rd_q : 8'd0;
  end

  logic [7:0] mem_val, cb_val;
  assign mem_val = mem_in_q ? mem_rd_q : 8'd0;
  assign cb_val  = cb_in_q ? cb_rd_q : 8'd0;

  logic [15:0] a_fill_dst, a_cp_src, a_cp_dst;
  assign a_fill_dst = {arg_q[1], arg_q[0]};
  assign a_cp_src   = {arg_q[1], arg_q[0]};
  assign a_cp_dst   = {arg_q[4], arg_q[3]};
  logic [15:0] cell_a;
  assign cell_a = rbase_q + {8'd0, col_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_READY;
      ptr_q    <= '0;
      wait_q   <= 1'b0;
      ov_q     <= 1'b0;
      ver_q    <= 8'd1;
      spr_q    <= 8'd0;
      opm_q    <= 8'd31;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      ptr_q    <= ptr_d;
      wait_q   <= wait_d;
      ov_q     <= ov_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_VERSION: ver_q <= cfg_data_i;
          CFG_SPRITES: spr_q <= cfg_data_i;
          CFG_OP_MASK: opm_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    idx_q <= idx_d; row_q <= row_d; col_q <= col_d;
    rbase_q <= rbase_d; k_q <= k_d; cmdb_q <= cmdb_d;
    rd_q <= rd_d; sv_q <= sv_d; sx_q <= sx_d; sy_q <= sy_d;
  end

  assign in_stall_o     = (state_q != S_IDLE) || ov_q;
  assign out_valid_o    = ov_q;
  assign read_data_o    = rd_q;
  assign status_code_o  = status_q;
  assign scroll_valid_o = sv_q;
  assign scroll_x_o     = sx_q;
  assign scroll_y_o     = sy_q;

  always_comb begin
    state_d = state_q; status_d = status_q; ptr_d = ptr_q; wait_d = wait_q;
    addr_d = addr_q; idx_d = idx_q;
    row_d = row_q; col_d = col_q; rbase_d = rbase_q; k_d = k_q; cmdb_d = cmdb_q;
    ov_d = ov_q; rd_d = rd_q; sv_d = sv_q; sx_d = sx_q; sy_d = sy_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_a = '0; mem_wd = '0;
    cb_we = 1'b0; cb_re = 1'b0; cb_a = '0; cb_wd = '0;
    arg_we = 1'b0; arg_wi = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          addr_d = address_i;
          rd_d = '0; sv_d = 1'b0; sx_d = '0; sy_d = '0;
          case (item_e'(command_i))
            ITEM_REG_RD: begin
              if (address_i == REG_CMD) rd_d = {5'd0, status_q};
              else if (address_i == REG_PTRL) rd_d = ptr_q[7:0];
              else if (address_i == REG_PTRH) rd_d = ptr_q[15:8];
              ov_d = 1'b1;
            end
            ITEM_REG_WR: begin
              if (address_i == REG_CMD) begin
                cmdb_d = write_data_i;
                if (ptr_q < GUARD_LOW || ptr_q > PTR_HIGH) begin
                  status_d = ST_BADADDR; ov_d = 1'b1;
                end else begin
                  status_d = ST_BUSY; idx_d = '0; state_d = S_ARG;
                end
              end else begin
                if (address_i == REG_PTRL) ptr_d = {ptr_q[15:8], write_data_i};
                else if (address_i == REG_PTRH) ptr_d = {write_data_i, ptr_q[7:0]};
                ov_d = 1'b1;
              end
            end
            ITEM_MEM_RD: begin
              mem_re = 1'b1; mem_a = address_i; state_d = S_MEMRD;
            end
            ITEM_MEM_WR: begin
              mem_we = 1'b1; mem_a = address_i; mem_wd = write_data_i; ov_d = 1'b1;
            end
            ITEM_VBLANK: begin
              if (wait_q) begin wait_d = 1'b0; status_d = ST_READY; end
              ov_d = 1'b1;
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      S_MEMRD: begin
        rd_d = mem_val; ov_d = 1'b1; state_d = S_IDLE;
      end
      S_ARG: begin
        // issue read idx, capture read idx-1
        if (idx_q != 5'd0) begin arg_we = 1'b1; arg_wi = 4'(idx_q - 5'd1); end
        if (idx_q != 5'd16) begin
          mem_re = 1'b1; mem_a = ptr_q + {11'd0, idx_q};
          idx_d = idx_q + 5'd1;
        end else begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_d = '0; row_d = '0; col_d = '0; k_d = '0;
        case (cmdb_q[6:0])
          OP_INFO: state_d = S_INFO;
          OP_FILL: begin
            if (a_fill_dst < GUARD_LOW) begin
              status_d = ST_BADADDR; state_d = S_DONE;
            end else begin
              rbase_d = a_fill_dst; state_d = S_FILL;
            end
          end
          OP_COPY: begin
            if (a_cp_src < GUARD_LOW || a_cp_dst < GUARD_LOW) begin
              status_d = ST_BADADDR; state_d = S_DONE;
            end else begin
              rbase_d = a_cp_src; state_d = S_CPRD;
            end
          end
          OP_SCROLL: begin
            sv_d = 1'b1; sx_d = arg_q[0]; sy_d = arg_q[1];
            status_d = ST_READY; state_d = S_DONE;
          end
          OP_WAIT: begin
            if (!cmdb_q[BLOCK_BIT]) status_d = ST_NOBLOCK;
            else wait_d = 1'b1;
            state_d = S_DONE;
          end
          default: begin status_d = ST_BADOP; state_d = S_DONE; end
        endcase
      end
      S_INFO: begin
        mem_we = 1'b1; mem_a = ptr_q + {11'd0, idx_q};
        case (idx_q[1:0])
          2'd0: mem_wd = (idx_q[4:2] == 3'd0) ? ver_q : 8'd0;
          2'd1: mem_wd = (idx_q[4:2] == 3'd0) ? spr_q : 8'd0;
          2'd2: mem_wd = (idx_q[4:2] == 3'd0) ? opm_q : 8'd0;
          default: mem_wd = 8'd0;
        endcase
        idx_d = idx_q + 5'd1;
        if (idx_q == 5'd15) begin status_d = ST_READY; state_d = S_DONE; end
      end
      S_FILL: begin
        if (row_q == arg_q[4] || arg_q[3] == 8'd0) begin
          status_d = ST_READY; state_d = S_DONE;
        end else begin
          if (cell_a >= GUARD_LOW) begin
            mem_we = 1'b1; mem_a = cell_a; mem_wd = arg_q[5];
          end
          if (col_q == arg_q[3] - 8'd1) begin
            col_d = '0; row_d = row_q + 8'd1; rbase_d = rbase_q + {8'd0, arg_q[2]};
          end else col_d = col_q + 8'd1;
        end
      end
      S_CPRD: begin
        if (row_q == arg_q[7] || arg_q[6] == 8'd0) begin
          row_d = '0; col_d = '0; k_d = '0; rbase_d = a_cp_dst; state_d = S_CPOUT;
        end else begin
          mem_re = 1'b1; mem_a = cell_a;
          addr_d = cell_a; state_d = S_CPWAIT;
        end
      end
      S_CPWAIT: state_d = S_CPST;
      S_CPST: begin
        cb_we = 1'b1; cb_a = k_q; cb_wd = (addr_q < GUARD_LOW) ? 8'd0 : mem_val;
        k_d = k_q + 17'd1;
        if (col_q == arg_q[6] - 8'd1) begin
          col_d = '0; row_d = row_q + 8'd1; rbase_d = rbase_q + {8'd0, arg_q[2]};
        end else col_d = col_q + 8'd1;
        state_d = S_CPRD;
      end
      S_CPOUT: begin
        if (row_q == arg_q[7] || arg_q[6] == 8'd0) begin
          status_d = ST_READY; state_d = S_DONE;
        end else begin
          cb_re = 1'b1; cb_a = k_q; state_d = S_CPOUTW;
        end
      end
      S_CPOUTW: state_d = S_CPWR;
      S_CPWR: begin
        if (cell_a >= GUARD_LOW) begin
          mem_we = 1'b1; mem_a = cell_a; mem_wd = cb_val;
        end
        k_d = k_q + 17'd1;
        if (col_q == arg_q[6] - 8'd1) begin
          col_d = '0; row_d = row_q + 8'd1; rbase_d = rbase_q + {8'd0, arg_q[5]};
        end else col_d = col_q + 8'd1;
        state_d = S_CPOUT;
      end
      S_DONE: begin
        ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
